FILE: hdl/clns_pkg.sv
package clns_pkg;

    // Fixed field widths of the streams and the register file.
    localparam int COORD_BITS     = 24;
    localparam int INV_BITS       = 24;
    localparam int IDENT_BITS     = 16;
    localparam int CUTOFF_BITS    = 50;
    localparam int CELLS_CFG_BITS = 5;
    localparam int CFG_DATA_BITS  = 50;
    localparam int CFG_INDEX_BITS = 3;
    localparam int S_TDATA_BITS   = 3 * COORD_BITS + IDENT_BITS;
    localparam int S_TUSER_BITS   = 2;
    localparam int M_TDATA_BITS   = IDENT_BITS;
    localparam int M_TUSER_BITS   = 4;

    // Defaults for the top-level parameters, and the fixed queue depth.
    localparam int CELLS_PER_AXIS_DEF = 16;
    localparam int CELL_CAPACITY_DEF  = 16;
    localparam int MAX_EMITTED_DEF    = 64;
    localparam int QUEUE_DEPTH        = 2;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_QUERY  = 2'd1,
        OP_CLEAR  = 2'd2
    } opcode_t;

    typedef enum logic [2:0] {
        KIND_NEIGHBOR = 3'd0,
        KIND_NONE     = 3'd1,
        KIND_INSERTED = 3'd2,
        KIND_DROPPED  = 3'd3,
        KIND_CLEARED  = 3'd4
    } kind_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_ORIGIN_X      = 3'd0,
        REG_ORIGIN_Y      = 3'd1,
        REG_ORIGIN_Z      = 3'd2,
        REG_INV_CELL_SIZE = 3'd3,
        REG_CELLS_X       = 3'd4,
        REG_CELLS_Y       = 3'd5,
        REG_CELLS_Z       = 3'd6,
        REG_CUTOFF_SQ     = 3'd7
    } cfg_reg_t;

    // One accepted command as it travels from front to back.
    typedef struct packed {
        logic [IDENT_BITS-1:0] ident;
        coord_t                pos_z;
        coord_t                pos_y;
        coord_t                pos_x;
        logic [1:0]            opcode;
    } cmd_t;

    // One stored atom.
    typedef struct packed {
        logic [IDENT_BITS-1:0] ident;
        coord_t                z;
        coord_t                y;
        coord_t                x;
    } slot_t;

endpackage

FILE: hdl/cell_list_neighbor_search.sv
// Cell-list neighbor search over a 3-D grid of up to CELLS_PER_AXIS cells
// per axis, each holding up to CELL_CAPACITY atoms.
// Input stream: one beat per command; s_tuser carries the opcode (insert,
// query, clear), s_tdata the position and the atom ident. Output stream:
// one beat per result; m_tlast marks the final beat of a command.
// Configuration: write cfg_data into register cfg_index with cfg_we while
// the block is idle.
// The front takes one command at a time, scales its offsets and pushes
// it on. An insert reads the fill count of its cell, stores the atom or
// drops it, then replies. A query reads the fill count of each neighbor
// cell in the grid and streams its stored atoms from the slot memory,
// held while the result register is stalled, then drains. A clear
// sweeps the fill memory. Reset: the fill memory (NUM_CELLS entries,
// 4096 at the default size) is swept to zero while commands queue up.
// A stalled receiver holds the result register; the front keeps taking
// commands until the two-entry queue is full, then drops s_tready.
module cell_list_neighbor_search #(
    parameter int CELLS_PER_AXIS = clns_pkg::CELLS_PER_AXIS_DEF,
    parameter int CELL_CAPACITY  = clns_pkg::CELL_CAPACITY_DEF,
    parameter int MAX_EMITTED    = clns_pkg::MAX_EMITTED_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // pos_x [23:0], pos_y [47:24], pos_z [71:48], atom_ident [87:72]
    input  logic [clns_pkg::S_TDATA_BITS-1:0]    s_tdata,
    // opcode [1:0]
    input  logic [clns_pkg::S_TUSER_BITS-1:0]    s_tuser,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // neighbor_ident [15:0]
    output logic [clns_pkg::M_TDATA_BITS-1:0]    m_tdata,
    // kind [2:0], truncated [3]
    output logic [clns_pkg::M_TUSER_BITS-1:0]    m_tuser,
    output logic                                 m_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic                                 cfg_we,
    input  logic [clns_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [clns_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    import clns_pkg::*;

    localparam int AXW = $clog2(CELLS_PER_AXIS);
    localparam int CNW = $clog2(CELLS_PER_AXIS + 1);
    localparam int QW  = $bits(cmd_t) + 3 * AXW;

    coord_t                    origin_x_reg;
    coord_t                    origin_y_reg;
    coord_t                    origin_z_reg;
    logic [INV_BITS-1:0]       inv_cell_size_reg;
    logic [CELLS_CFG_BITS-1:0] cells_x_reg;
    logic [CELLS_CFG_BITS-1:0] cells_y_reg;
    logic [CELLS_CFG_BITS-1:0] cells_z_reg;
    logic [CUTOFF_BITS-1:0]    cutoff_sq_reg;

    logic           q_push;
    logic [QW-1:0]  q_push_data;
    logic           q_full;
    logic           q_pop;
    logic [QW-1:0]  q_pop_data;
    logic           q_valid;
    logic [CNW-1:0] nx;
    logic [CNW-1:0] ny;
    logic [CNW-1:0] nz;

    // Register file.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg      <= '0;
            origin_y_reg      <= '0;
            origin_z_reg      <= '0;
            inv_cell_size_reg <= INV_BITS'(4096);
            cells_x_reg       <= CELLS_CFG_BITS'(1);
            cells_y_reg       <= CELLS_CFG_BITS'(1);
            cells_z_reg       <= CELLS_CFG_BITS'(1);
            cutoff_sq_reg     <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_ORIGIN_X:      origin_x_reg      <= cfg_data[COORD_BITS-1:0];
                REG_ORIGIN_Y:      origin_y_reg      <= cfg_data[COORD_BITS-1:0];
                REG_ORIGIN_Z:      origin_z_reg      <= cfg_data[COORD_BITS-1:0];
                REG_INV_CELL_SIZE: inv_cell_size_reg <= cfg_data[INV_BITS-1:0];
                REG_CELLS_X:       cells_x_reg       <= cfg_data[CELLS_CFG_BITS-1:0];
                REG_CELLS_Y:       cells_y_reg       <= cfg_data[CELLS_CFG_BITS-1:0];
                REG_CELLS_Z:       cells_z_reg       <= cfg_data[CELLS_CFG_BITS-1:0];
                REG_CUTOFF_SQ:     cutoff_sq_reg     <= cfg_data[CUTOFF_BITS-1:0];
                default:           cutoff_sq_reg     <= cutoff_sq_reg;
            endcase
        end
    end

    // Command intake and cell coordinates.
    clns_front #(
        .CELLS_PER_AXIS (CELLS_PER_AXIS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .origin_x      (origin_x_reg),
        .origin_y      (origin_y_reg),
        .origin_z      (origin_z_reg),
        .inv_cell_size (inv_cell_size_reg),
        .cells_x       (cells_x_reg),
        .cells_y       (cells_y_reg),
        .cells_z       (cells_z_reg),
        .q_push        (q_push),
        .q_data        (q_push_data),
        .q_full        (q_full),
        .nx            (nx),
        .ny            (ny),
        .nz            (nz)
    );

    // Command queue between the two halves.
    clns_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .valid     (q_valid)
    );

    // Cell storage, scan engine and result register.
    clns_back #(
        .CELLS_PER_AXIS (CELLS_PER_AXIS),
        .CELL_CAPACITY  (CELL_CAPACITY),
        .MAX_EMITTED    (MAX_EMITTED)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_data    (q_pop_data),
        .nx        (nx),
        .ny        (ny),
        .nz        (nz),
        .cutoff_sq (cutoff_sq_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // A truncated run is flagged only on its final beat.
    a_trunc_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[3] |-> m_tlast && (m_tuser[2:0] == KIND_NEIGHBOR))
        else $error("truncated flag on a beat that does not end a query");

    // Status results are single beats with a zero ident.
    a_status_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[2:0] != KIND_NEIGHBOR) |-> m_tlast && (m_tdata == '0))
        else $error("status result is not a single beat with zero ident");

endmodule

FILE: hdl/clns_queue.sv
module clns_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             valid
);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_data = entry_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: hdl/clns_front.sv
module clns_front #(
    parameter int CELLS_PER_AXIS = clns_pkg::CELLS_PER_AXIS_DEF,
    localparam int AXW = $clog2(CELLS_PER_AXIS),
    localparam int CNW = $clog2(CELLS_PER_AXIS + 1),
    localparam int QW  = $bits(clns_pkg::cmd_t) + 3 * AXW
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [clns_pkg::S_TDATA_BITS-1:0]    s_tdata,
    input  logic [clns_pkg::S_TUSER_BITS-1:0]    s_tuser,
    input  clns_pkg::coord_t                     origin_x,
    input  clns_pkg::coord_t                     origin_y,
    input  clns_pkg::coord_t                     origin_z,
    input  logic [clns_pkg::INV_BITS-1:0]        inv_cell_size,
    input  logic [clns_pkg::CELLS_CFG_BITS-1:0]  cells_x,
    input  logic [clns_pkg::CELLS_CFG_BITS-1:0]  cells_y,
    input  logic [clns_pkg::CELLS_CFG_BITS-1:0]  cells_z,
    output logic                                 q_push,
    output logic [QW-1:0]                        q_data,
    input  logic                                 q_full,
    output logic [CNW-1:0]                       nx,
    output logic [CNW-1:0]                       ny,
    output logic [CNW-1:0]                       nz
);

    import clns_pkg::*;

    localparam int CCW = (CNW > CELLS_CFG_BITS) ? CNW : CELLS_CFG_BITS;
    localparam int PW  = COORD_BITS + INV_BITS;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_PUSH
    } fstate_t;

    fstate_t          state_reg;
    cmd_t             cmd_reg;
    logic [PW-1:0]    prod_x_reg;
    logic [PW-1:0]    prod_y_reg;
    logic [PW-1:0]    prod_z_reg;
    logic [AXW-1:0]   ix;
    logic [AXW-1:0]   iy;
    logic [AXW-1:0]   iz;

    // A zero cell count acts as one, a large one as the grid size.
    function automatic logic [CNW-1:0] axis_count(input logic [CELLS_CFG_BITS-1:0] c);
        logic [CCW-1:0] e;
        e = CCW'(c);
        if (e == '0)
        begin
            return CNW'(1);
        end
        if (e > CCW'(CELLS_PER_AXIS))
        begin
            return CNW'(CELLS_PER_AXIS);
        end
        return CNW'(e);
    endfunction

    // Offset from the origin, with positions below it pinned to zero.
    function automatic logic [COORD_BITS-1:0] axis_offset(input coord_t p, input coord_t o);
        logic [COORD_BITS:0] d;
        d = {p[COORD_BITS-1], p} - {o[COORD_BITS-1], o};
        return d[COORD_BITS] ? '0 : d[COORD_BITS-1:0];
    endfunction

    // Integer part of the scaled offset, clamped to the last cell.
    function automatic logic [AXW-1:0] axis_clamp(input logic [PW-1:0] p,
                                                  input logic [CNW-1:0] n);
        logic [INV_BITS-1:0] c;
        logic [CNW-1:0]      nm1;
        c   = p[PW-1:COORD_BITS];
        nm1 = n - 1'b1;
        return (c > INV_BITS'(nm1)) ? AXW'(nm1) : AXW'(c);
    endfunction

    assign nx = axis_count(cells_x);
    assign ny = axis_count(cells_y);
    assign nz = axis_count(cells_z);

    assign s_tready = (state_reg == F_IDLE);
    assign ix       = axis_clamp(prod_x_reg, nx);
    assign iy       = axis_clamp(prod_y_reg, ny);
    assign iz       = axis_clamp(prod_z_reg, nz);
    assign q_push   = (state_reg == F_PUSH) && !q_full;
    assign q_data   = {iz, iy, ix, cmd_reg};

    // Accept a beat, scale the offsets, then hand the command on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        state_reg <= F_MUL;
                    end
                end
                F_MUL:
                begin
                    state_reg <= F_PUSH;
                end
                F_PUSH:
                begin
                    if (!q_full)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

    // Command capture and the per-axis products.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            cmd_reg.opcode <= s_tuser;
            cmd_reg.pos_x  <= s_tdata[0 +: COORD_BITS];
            cmd_reg.pos_y  <= s_tdata[COORD_BITS +: COORD_BITS];
            cmd_reg.pos_z  <= s_tdata[2*COORD_BITS +: COORD_BITS];
            cmd_reg.ident  <= s_tdata[3*COORD_BITS +: IDENT_BITS];
        end
        if (state_reg == F_MUL)
        begin
            prod_x_reg <= PW'(axis_offset(cmd_reg.pos_x, origin_x)) * PW'(inv_cell_size);
            prod_y_reg <= PW'(axis_offset(cmd_reg.pos_y, origin_y)) * PW'(inv_cell_size);
            prod_z_reg <= PW'(axis_offset(cmd_reg.pos_z, origin_z)) * PW'(inv_cell_size);
        end
    end

endmodule

FILE: hdl/clns_back.sv
module clns_back #(
    parameter int CELLS_PER_AXIS = clns_pkg::CELLS_PER_AXIS_DEF,
    parameter int CELL_CAPACITY  = clns_pkg::CELL_CAPACITY_DEF,
    parameter int MAX_EMITTED    = clns_pkg::MAX_EMITTED_DEF,
    localparam int AXW = $clog2(CELLS_PER_AXIS),
    localparam int CNW = $clog2(CELLS_PER_AXIS + 1),
    localparam int QW  = $bits(clns_pkg::cmd_t) + 3 * AXW
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_valid,
    output logic                               q_pop,
    input  logic [QW-1:0]                      q_data,
    input  logic [CNW-1:0]                     nx,
    input  logic [CNW-1:0]                     ny,
    input  logic [CNW-1:0]                     nz,
    input  logic [clns_pkg::CUTOFF_BITS-1:0]   cutoff_sq,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [clns_pkg::M_TDATA_BITS-1:0]  m_tdata,
    output logic [clns_pkg::M_TUSER_BITS-1:0]  m_tuser,
    output logic                               m_tlast
);

    import clns_pkg::*;

    localparam int NUM_CELLS = CELLS_PER_AXIS * CELLS_PER_AXIS * CELLS_PER_AXIS;
    localparam int NUM_SLOTS = NUM_CELLS * CELL_CAPACITY;
    localparam int CIW       = $clog2(NUM_CELLS);
    localparam int SAW       = $clog2(NUM_SLOTS);
    localparam int FW        = $clog2(CELL_CAPACITY + 1);
    localparam int NW        = $clog2(MAX_EMITTED + 1);
    localparam int CMW       = $bits(cmd_t);
    localparam int DW        = COORD_BITS + 1;
    localparam int SQW       = 2 * DW;
    localparam int JW        = AXW + 2;

    typedef enum logic [3:0] {
        B_CLEAR,
        B_IDLE,
        B_INS_CELL,
        B_INS_RD,
        B_INS_CHK,
        B_Q_CELL,
        B_Q_FRD,
        B_Q_FWAIT,
        B_Q_SLOTS,
        B_Q_DRAIN,
        B_Q_DONE,
        B_REPLY
    } bstate_t;

    // Control state.
    bstate_t          state_reg;
    logic [CIW-1:0]   clr_cnt_reg;
    logic             clr_reply_reg;
    kind_t            reply_kind_reg;
    logic [1:0]       dx_reg;
    logic [1:0]       dy_reg;
    logic [1:0]       dz_reg;
    logic [FW-1:0]    k_reg;
    logic [FW-1:0]    fill_cnt_reg;
    logic [NW-1:0]    n_reg;
    logic             trunc_reg;
    logic             pend_v_reg;
    logic             rd_v_reg;
    logic             p2_v_reg;
    logic             p3_v_reg;
    logic             out_v_reg;

    // Payload.
    cmd_t             cmd_reg;
    logic [AXW-1:0]   ix_reg;
    logic [AXW-1:0]   iy_reg;
    logic [AXW-1:0]   iz_reg;
    logic [CIW-1:0]   cell_reg;
    logic [SAW-1:0]   base_reg;
    logic [2*CNW-1:0] nyz_reg;
    logic [IDENT_BITS-1:0] pend_id_reg;
    logic [IDENT_BITS-1:0] out_id_reg;
    kind_t            out_kind_reg;
    logic             out_trunc_reg;
    logic             out_last_reg;
    logic [DW-1:0]    ax_reg;
    logic [DW-1:0]    ay_reg;
    logic [DW-1:0]    az_reg;
    logic [IDENT_BITS-1:0] p2_id_reg;
    logic [SQW-1:0]   sqx_reg;
    logic [SQW-1:0]   sqy_reg;
    logic [SQW-1:0]   sqz_reg;
    logic [IDENT_BITS-1:0] p3_id_reg;

    // Memories.
    logic [FW-1:0]    fill_mem [NUM_CELLS];
    slot_t            slot_mem [NUM_SLOTS];
    logic [FW-1:0]    fill_rdata;
    slot_t            slot_rd;

    logic             fill_we;
    logic [CIW-1:0]   fill_waddr;
    logic [FW-1:0]    fill_wdata;
    logic             slot_we;
    logic [SAW-1:0]   slot_waddr;
    slot_t            slot_wdata;
    logic [SAW-1:0]   slot_raddr;
    logic             cell_full;
    logic             issue;
    logic             stall;
    logic             hit;
    logic [SQW-1:0]   d2;
    logic             out_free;
    logic             dir_last;
    logic [1:0]       dx_next;
    logic [1:0]       dy_next;
    logic [1:0]       dz_next;
    logic [JW-1:0]    jx;
    logic [JW-1:0]    jy;
    logic [JW-1:0]    jz;
    logic             j_in_grid;
    logic [AXW-1:0]   lx;
    logic [AXW-1:0]   ly;
    logic [AXW-1:0]   lz;
    logic [CIW-1:0]   lin;
    cmd_t             q_cmd;

    assign q_cmd = q_data[CMW-1:0];
    assign q_pop = (state_reg == B_IDLE) && q_valid;

    // Neighbor cell coordinates for the current direction.
    always_comb
    begin
        jx = JW'(ix_reg) + JW'(dx_reg) - JW'(1);
        jy = JW'(iy_reg) + JW'(dy_reg) - JW'(1);
        jz = JW'(iz_reg) + JW'(dz_reg) - JW'(1);
        j_in_grid = !jx[JW-1] && (jx < JW'(nx)) &&
                    !jy[JW-1] && (jy < JW'(ny)) &&
                    !jz[JW-1] && (jz < JW'(nz));
    end

    // Linear cell index, x slowest and z fastest.
    always_comb
    begin
        if (state_reg == B_Q_CELL)
        begin
            lx = jx[AXW-1:0];
            ly = jy[AXW-1:0];
            lz = jz[AXW-1:0];
        end
        else
        begin
            lx = ix_reg;
            ly = iy_reg;
            lz = iz_reg;
        end
        lin = CIW'(lx) * CIW'(nyz_reg) + CIW'(ly) * CIW'(nz) + CIW'(lz);
    end

    // Step through the 27 directions with z innermost.
    always_comb
    begin
        dir_last = (dx_reg == 2'd2) && (dy_reg == 2'd2) && (dz_reg == 2'd2);
        dx_next  = dx_reg;
        dy_next  = dy_reg;
        dz_next  = dz_reg + 2'd1;
        if (dz_reg == 2'd2)
        begin
            dz_next = 2'd0;
            dy_next = dy_reg + 2'd1;
            if (dy_reg == 2'd2)
            begin
                dy_next = 2'd0;
                dx_next = dx_reg + 2'd1;
            end
        end
    end

    // Memory ports.
    always_comb
    begin
        cell_full  = (fill_rdata >= FW'(CELL_CAPACITY));
        fill_we    = (state_reg == B_CLEAR) || ((state_reg == B_INS_CHK) && !cell_full);
        fill_waddr = (state_reg == B_CLEAR) ? clr_cnt_reg : cell_reg;
        fill_wdata = (state_reg == B_CLEAR) ? '0 : fill_rdata + 1'b1;
        slot_we    = (state_reg == B_INS_CHK) && !cell_full;
        slot_waddr = base_reg + SAW'(fill_rdata);
        slot_wdata.x     = cmd_reg.pos_x;
        slot_wdata.y     = cmd_reg.pos_y;
        slot_wdata.z     = cmd_reg.pos_z;
        slot_wdata.ident = cmd_reg.ident;
        slot_raddr = base_reg + SAW'(k_reg);
    end

    // Distance test at the end of the slot pipeline. Every axis difference
    // of two 24-bit positions stays below 2^26, so no far-apart check.
    always_comb
    begin
        d2       = sqx_reg + sqy_reg + sqz_reg;
        hit      = p3_v_reg && (d2 != '0) && (d2 <= SQW'(cutoff_sq));
        out_free = !out_v_reg || m_tready;
        stall    = hit && (n_reg < NW'(MAX_EMITTED)) && pend_v_reg && !out_free;
        issue    = (state_reg == B_Q_SLOTS) && (k_reg != fill_cnt_reg) && !stall;
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_id_reg;
    assign m_tuser  = {out_trunc_reg, out_kind_reg};
    assign m_tlast  = out_last_reg;

    // Sequencer, hit collection and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_CLEAR;
            clr_cnt_reg    <= '0;
            clr_reply_reg  <= 1'b0;
            reply_kind_reg <= KIND_NONE;
            dx_reg         <= '0;
            dy_reg         <= '0;
            dz_reg         <= '0;
            k_reg          <= '0;
            fill_cnt_reg   <= '0;
            n_reg          <= '0;
            trunc_reg      <= 1'b0;
            pend_v_reg     <= 1'b0;
            rd_v_reg       <= 1'b0;
            p2_v_reg       <= 1'b0;
            p3_v_reg       <= 1'b0;
            out_v_reg      <= 1'b0;
            nyz_reg        <= '0;
        end
        else
        begin
            nyz_reg <= (2*CNW)'(ny) * (2*CNW)'(nz);

            if (m_tready)
            begin
                out_v_reg <= 1'b0;
            end

            if (!stall)
            begin
                rd_v_reg <= issue;
                p2_v_reg <= rd_v_reg;
                p3_v_reg <= p2_v_reg;
            end

            // A new hit pushes the held one out; the newest is kept back
            // so that it can carry the end-of-run flags.
            if (hit && !stall)
            begin
                if (n_reg < NW'(MAX_EMITTED))
                begin
                    n_reg       <= n_reg + 1'b1;
                    pend_v_reg  <= 1'b1;
                    pend_id_reg <= p3_id_reg;
                    if (pend_v_reg)
                    begin
                        out_v_reg     <= 1'b1;
                        out_id_reg    <= pend_id_reg;
                        out_kind_reg  <= KIND_NEIGHBOR;
                        out_trunc_reg <= 1'b0;
                        out_last_reg  <= 1'b0;
                    end
                end
                else
                begin
                    trunc_reg <= 1'b1;
                end
            end

            case (state_reg)
                B_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == CIW'(NUM_CELLS - 1))
                    begin
                        clr_cnt_reg    <= '0;
                        reply_kind_reg <= KIND_CLEARED;
                        state_reg      <= clr_reply_reg ? B_REPLY : B_IDLE;
                    end
                end
                B_IDLE:
                begin
                    if (q_valid)
                    begin
                        cmd_reg <= q_cmd;
                        ix_reg  <= q_data[CMW +: AXW];
                        iy_reg  <= q_data[CMW + AXW +: AXW];
                        iz_reg  <= q_data[CMW + 2*AXW +: AXW];
                        case (opcode_t'(q_cmd.opcode))
                            OP_INSERT:
                            begin
                                state_reg <= B_INS_CELL;
                            end
                            OP_QUERY:
                            begin
                                n_reg      <= '0;
                                trunc_reg  <= 1'b0;
                                pend_v_reg <= 1'b0;
                                dx_reg     <= '0;
                                dy_reg     <= '0;
                                dz_reg     <= '0;
                                state_reg  <= B_Q_CELL;
                            end
                            OP_CLEAR:
                            begin
                                clr_reply_reg <= 1'b1;
                                state_reg     <= B_CLEAR;
                            end
                            default:
                            begin
                                state_reg <= B_IDLE;
                            end
                        endcase
                    end
                end
                B_INS_CELL:
                begin
                    cell_reg  <= lin;
                    state_reg <= B_INS_RD;
                end
                B_INS_RD:
                begin
                    base_reg  <= SAW'(cell_reg) * SAW'(CELL_CAPACITY);
                    state_reg <= B_INS_CHK;
                end
                B_INS_CHK:
                begin
                    reply_kind_reg <= cell_full ? KIND_DROPPED : KIND_INSERTED;
                    state_reg      <= B_REPLY;
                end
                B_Q_CELL:
                begin
                    if (j_in_grid)
                    begin
                        cell_reg  <= lin;
                        state_reg <= B_Q_FRD;
                    end
                    else
                    begin
                        dx_reg    <= dx_next;
                        dy_reg    <= dy_next;
                        dz_reg    <= dz_next;
                        state_reg <= dir_last ? B_Q_DRAIN : B_Q_CELL;
                    end
                end
                B_Q_FRD:
                begin
                    base_reg  <= SAW'(cell_reg) * SAW'(CELL_CAPACITY);
                    state_reg <= B_Q_FWAIT;
                end
                B_Q_FWAIT:
                begin
                    fill_cnt_reg <= fill_rdata;
                    k_reg        <= '0;
                    state_reg    <= B_Q_SLOTS;
                end
                B_Q_SLOTS:
                begin
                    if (k_reg == fill_cnt_reg)
                    begin
                        dx_reg    <= dx_next;
                        dy_reg    <= dy_next;
                        dz_reg    <= dz_next;
                        state_reg <= dir_last ? B_Q_DRAIN : B_Q_CELL;
                    end
                    else if (issue)
                    begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                B_Q_DRAIN:
                begin
                    if (!rd_v_reg && !p2_v_reg && !p3_v_reg)
                    begin
                        state_reg <= B_Q_DONE;
                    end
                end
                B_Q_DONE:
                begin
                    if (out_free)
                    begin
                        out_v_reg    <= 1'b1;
                        out_last_reg <= 1'b1;
                        if (n_reg == '0)
                        begin
                            out_id_reg    <= '0;
                            out_kind_reg  <= KIND_NONE;
                            out_trunc_reg <= 1'b0;
                        end
                        else
                        begin
                            out_id_reg    <= pend_id_reg;
                            out_kind_reg  <= KIND_NEIGHBOR;
                            out_trunc_reg <= trunc_reg;
                        end
                        pend_v_reg <= 1'b0;
                        state_reg  <= B_IDLE;
                    end
                end
                B_REPLY:
                begin
                    if (out_free)
                    begin
                        out_v_reg     <= 1'b1;
                        out_id_reg    <= '0;
                        out_kind_reg  <= reply_kind_reg;
                        out_trunc_reg <= 1'b0;
                        out_last_reg  <= 1'b1;
                        clr_reply_reg <= 1'b0;
                        state_reg     <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    // Slot pipeline: absolute differences, then squares.
    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            ax_reg    <= ($signed(slot_rd.x) > $signed(cmd_reg.pos_x)) ?
                         DW'({slot_rd.x[COORD_BITS-1], slot_rd.x} -
                             {cmd_reg.pos_x[COORD_BITS-1], cmd_reg.pos_x}) :
                         DW'({cmd_reg.pos_x[COORD_BITS-1], cmd_reg.pos_x} -
                             {slot_rd.x[COORD_BITS-1], slot_rd.x});
            ay_reg    <= ($signed(slot_rd.y) > $signed(cmd_reg.pos_y)) ?
                         DW'({slot_rd.y[COORD_BITS-1], slot_rd.y} -
                             {cmd_reg.pos_y[COORD_BITS-1], cmd_reg.pos_y}) :
                         DW'({cmd_reg.pos_y[COORD_BITS-1], cmd_reg.pos_y} -
                             {slot_rd.y[COORD_BITS-1], slot_rd.y});
            az_reg    <= ($signed(slot_rd.z) > $signed(cmd_reg.pos_z)) ?
                         DW'({slot_rd.z[COORD_BITS-1], slot_rd.z} -
                             {cmd_reg.pos_z[COORD_BITS-1], cmd_reg.pos_z}) :
                         DW'({cmd_reg.pos_z[COORD_BITS-1], cmd_reg.pos_z} -
                             {slot_rd.z[COORD_BITS-1], slot_rd.z});
            p2_id_reg <= slot_rd.ident;
            sqx_reg   <= SQW'(ax_reg) * SQW'(ax_reg);
            sqy_reg   <= SQW'(ay_reg) * SQW'(ay_reg);
            sqz_reg   <= SQW'(az_reg) * SQW'(az_reg);
            p3_id_reg <= p2_id_reg;
        end
    end

    // Fill counts per cell.
    always_ff @(posedge clk)
    begin
        if (fill_we)
        begin
            fill_mem[fill_waddr] <= fill_wdata;
        end
        fill_rdata <= fill_mem[cell_reg];
    end

    // Stored atoms.
    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        if (!stall)
        begin
            slot_rd <= slot_mem[slot_raddr];
        end
    end

endmodule

FILE: bench/cell_list_neighbor_search_tb.sv
`timescale 1ns / 1ps

module cell_list_neighbor_search_tb;

    import clns_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         GRID_AXIS   = CELLS_PER_AXIS_DEF;
    localparam int         CELL_SLOTS  = CELL_CAPACITY_DEF;
    localparam int         EMIT_LIMIT  = MAX_EMITTED_DEF;
    localparam int         GRID_CELLS  = GRID_AXIS * GRID_AXIS * GRID_AXIS;
    localparam int         SETTLE_WAIT = 5000;
    localparam int         STALL_LIMIT = 50000;
    localparam longint     ONE         = 4096;
    localparam longint     CUTOFF_MAX  = (64'd1 << CUTOFF_BITS) - 1;

    // One command for the block.
    typedef struct {
        logic [1:0]            op;
        coord_t                x;
        coord_t                y;
        coord_t                z;
        logic [IDENT_BITS-1:0] ident;
    } command_t;

    // One result beat as the block should send it.
    typedef struct {
        logic [IDENT_BITS-1:0] ident;
        kind_t                 kind;
        logic                  trunc;
        logic                  last;
    } result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic [S_TDATA_BITS-1:0] s_tdata = '0;
    logic [S_TUSER_BITS-1:0] s_tuser = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [M_TDATA_BITS-1:0] m_tdata;
    logic [M_TUSER_BITS-1:0] m_tuser;
    logic m_tlast;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    // Shadow registers and grid contents.
    longint org_x, org_y, org_z, inv_size, ncells_x, ncells_y, ncells_z, cutoff;
    int     cell_count [GRID_CELLS];
    coord_t atom_x [GRID_CELLS*CELL_SLOTS];
    coord_t atom_y [GRID_CELLS*CELL_SLOTS];
    coord_t atom_z [GRID_CELLS*CELL_SLOTS];
    logic [IDENT_BITS-1:0] atom_id [GRID_CELLS*CELL_SLOTS];

    command_t cmd_backlog[$];
    command_t cmd_on_bus;
    bit       cmd_busy = 1'b0;
    result_t  expected_results[$];
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    int       fail_count = 0;
    int       quiet_cycles = 0;
    coord_t   last_x = '0, last_y = '0, last_z = '0;

    cell_list_neighbor_search u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // Clock.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    function automatic longint clamp_count(input longint c);
        if (c == 0)
            return 1;
        if (c > GRID_AXIS)
            return GRID_AXIS;
        return c;
    endfunction

    // Cell index along one axis, clamped to the grid.
    function automatic longint axis_index(input longint pos, input longint org,
                                          input longint n);
        longint d;
        longint c;
        d = pos - org;
        if (d < 0)
            return 0;
        c = (d * inv_size) >>> 24;
        return (c > n - 1) ? n - 1 : c;
    endfunction

    function automatic longint abs_diff(input longint a, input longint b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Appends one expected beat to the scoreboard.
    task automatic expect_beat(input result_t r);
        expected_results = {expected_results, r};
    endtask

    task automatic push_single(input kind_t kind);
        result_t r;
        r.ident = '0;
        r.kind  = kind;
        r.trunc = 1'b0;
        r.last  = 1'b1;
        expect_beat(r);
    endtask

    // Works out the result beats that one accepted command causes.
    task automatic predict_results(input command_t c);
        longint nx, ny, nz, ix, iy, iz, jx, jy, jz, cell_idx, slot, ax, ay, az, d2;
        int     found;
        bit     overflow;
        result_t r;
        nx = clamp_count(ncells_x);
        ny = clamp_count(ncells_y);
        nz = clamp_count(ncells_z);
        ix = axis_index(longint'(c.x), org_x, nx);
        iy = axis_index(longint'(c.y), org_y, ny);
        iz = axis_index(longint'(c.z), org_z, nz);
        found = 0;
        overflow = 1'b0;
        if (c.op == OP_INSERT)
        begin
            cell_idx = ix * ny * nz + iy * nz + iz;
            if (cell_count[cell_idx] >= CELL_SLOTS)
                push_single(KIND_DROPPED);
            else
            begin
                slot = cell_idx * CELL_SLOTS + cell_count[cell_idx];
                atom_x[slot] = c.x;
                atom_y[slot] = c.y;
                atom_z[slot] = c.z;
                atom_id[slot] = c.ident;
                cell_count[cell_idx]++;
                push_single(KIND_INSERTED);
            end
        end
        else if (c.op == OP_QUERY)
        begin
            for (int dx = -1; dx <= 1; dx++)
                for (int dy = -1; dy <= 1; dy++)
                    for (int dz = -1; dz <= 1; dz++)
                    begin
                        jx = ix + dx;
                        jy = iy + dy;
                        jz = iz + dz;
                        if (jx < 0 || jx >= nx || jy < 0 || jy >= ny || jz < 0 || jz >= nz)
                            continue;
                        cell_idx = jx * ny * nz + jy * nz + jz;
                        for (int k = 0; k < cell_count[cell_idx]; k++)
                        begin
                            slot = cell_idx * CELL_SLOTS + k;
                            ax = abs_diff(longint'(c.x), longint'(atom_x[slot]));
                            ay = abs_diff(longint'(c.y), longint'(atom_y[slot]));
                            az = abs_diff(longint'(c.z), longint'(atom_z[slot]));
                            if (ax >= (64'd1 << 26) || ay >= (64'd1 << 26) ||
                                az >= (64'd1 << 26))
                                continue;
                            d2 = ax * ax + ay * ay + az * az;
                            if (d2 == 0 || d2 > cutoff)
                                continue;
                            if (found < EMIT_LIMIT)
                            begin
                                r.ident = atom_id[slot];
                                r.kind  = KIND_NEIGHBOR;
                                r.trunc = 1'b0;
                                r.last  = 1'b0;
                                expect_beat(r);
                                found++;
                            end
                            else
                                overflow = 1'b1;
                        end
                    end
            if (found == 0)
                push_single(KIND_NONE);
            else
            begin
                expected_results[$].trunc = overflow;
                expected_results[$].last  = 1'b1;
            end
        end
        else if (c.op == OP_CLEAR)
        begin
            foreach (cell_count[i])
                cell_count[i] = 0;
            push_single(KIND_CLEARED);
        end
    endtask

    // Input driver: presents queued commands, idling at random.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                predict_results(cmd_on_bus);
                cmd_busy = 1'b0;
            end
            if (!s_tvalid || s_tready)
            begin
                if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    cmd_on_bus = cmd_backlog.pop_front();
                    cmd_busy = 1'b1;
                    s_tdata  <= {cmd_on_bus.ident, cmd_on_bus.z, cmd_on_bus.y, cmd_on_bus.x};
                    s_tuser  <= cmd_on_bus.op;
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Output back-pressure.
    always @(posedge clk)
    begin
        m_tready <= rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Result checker and watchdog.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("unexpected beat ident=%h tuser=%h last=%b",
                                              m_tdata, m_tuser, m_tlast));
                else
                begin
                    want = expected_results.pop_front();
                    if (m_tdata !== want.ident)
                        report_mismatch($sformatf("ident %h, want %h", m_tdata, want.ident));
                    if (m_tuser[2:0] !== want.kind)
                        report_mismatch($sformatf("kind %0d, want %0d", m_tuser[2:0],
                                                  want.kind));
                    if (m_tuser[3] !== want.trunc)
                        report_mismatch($sformatf("truncated %b, want %b", m_tuser[3],
                                                  want.trunc));
                    if (m_tlast !== want.last)
                        report_mismatch($sformatf("last %b, want %b", m_tlast, want.last));
                end
            end
            // Count only cycles where work is outstanding and nothing moves.
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cmd_backlog.size() == 0 && !cmd_busy && expected_results.size() == 0))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Register write, mirrored into the shadow copy.
    task automatic write_reg(input cfg_reg_t idx, input longint value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_BITS-1:0];
        case (idx)
            REG_ORIGIN_X:      org_x = longint'(signed'(value[23:0]));
            REG_ORIGIN_Y:      org_y = longint'(signed'(value[23:0]));
            REG_ORIGIN_Z:      org_z = longint'(signed'(value[23:0]));
            REG_INV_CELL_SIZE: inv_size = value & 64'hFF_FFFF;
            REG_CELLS_X:       ncells_x = value & 31;
            REG_CELLS_Y:       ncells_y = value & 31;
            REG_CELLS_Z:       ncells_z = value & 31;
            REG_CUTOFF_SQ:     cutoff = value & CUTOFF_MAX;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_grid(input longint ox, input longint oy, input longint oz,
                              input longint inv, input longint cx, input longint cy,
                              input longint cz, input longint cut);
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_ORIGIN_Z, oz);
        write_reg(REG_INV_CELL_SIZE, inv);
        write_reg(REG_CELLS_X, cx);
        write_reg(REG_CELLS_Y, cy);
        write_reg(REG_CELLS_Z, cz);
        write_reg(REG_CUTOFF_SQ, cut);
    endtask

    task automatic queue_cmd(input logic [1:0] op, input longint x, input longint y,
                             input longint z, input logic [IDENT_BITS-1:0] ident);
        command_t c;
        c.op = op;
        c.x = x[23:0];
        c.y = y[23:0];
        c.z = z[23:0];
        c.ident = ident;
        cmd_backlog = {cmd_backlog, c};
    endtask

    // Mostly commands inside a window around the grid; some fully random.
    task automatic queue_random(input int count, input longint base, input longint span);
        int     pick;
        longint x, y, z;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            x = base + $urandom_range(0, span);
            y = base + $urandom_range(0, span);
            z = base + $urandom_range(0, span);
            if (pick < 15)
                queue_cmd(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                          IDENT_BITS'($urandom));
            else if (pick < 65)
            begin
                queue_cmd(OP_INSERT, x, y, z, IDENT_BITS'($urandom));
                last_x = x[23:0];
                last_y = y[23:0];
                last_z = z[23:0];
            end
            else if (pick < 77)
                queue_cmd(OP_QUERY, last_x, last_y, last_z, IDENT_BITS'($urandom));
            else if (pick < 95)
                queue_cmd(OP_QUERY, x, y, z, IDENT_BITS'($urandom));
            else if (pick < 97)
                queue_cmd(OP_CLEAR, x, y, z, IDENT_BITS'($urandom));
            else
                queue_cmd(OP_UNUSED, x, y, z, IDENT_BITS'($urandom));
        end
    endtask

    // Waits until every command is in and every result is out, then lets
    // the block finish any work that gives no result.
    task automatic settle();
        wait (cmd_backlog.size() == 0 && !cmd_busy && expected_results.size() == 0);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    initial
    begin
        org_x = 0;
        org_y = 0;
        org_z = 0;
        inv_size = ONE;
        ncells_x = 1;
        ncells_y = 1;
        ncells_z = 1;
        cutoff = 0;
        foreach (cell_count[i])
            cell_count[i] = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Unit cells, 4 per axis, cutoff of about 1.4.
        write_grid(0, 0, 0, ONE, 4, 4, 4, 2 * (ONE * ONE));
        queue_cmd(OP_CLEAR, 0, 0, 0, 0);
        queue_cmd(OP_UNUSED, 100, 200, 300, 16'h1234);
        queue_cmd(OP_QUERY, ONE, ONE, ONE, 0);
        queue_cmd(OP_INSERT, 2048, 2048, 2048, 16'h0000);
        queue_cmd(OP_INSERT, 4096, 2048, 2048, 16'hFFFF);
        queue_cmd(OP_INSERT, 2048, 2048, 2048, 16'h0007);
        queue_cmd(OP_QUERY, 2048, 2048, 2048, 0);
        queue_cmd(OP_INSERT, 8388607, 8388607, 8388607, 16'hA5A5);
        queue_cmd(OP_INSERT, -8388608, -8388608, -8388608, 16'h5A5A);
        queue_cmd(OP_QUERY, 8388607, 8388607, 8388607, 0);
        queue_cmd(OP_QUERY, -8388608, -8388608, -8388608, 0);
        // Fill cell zero past its capacity.
        for (int k = 0; k < 14; k++)
            queue_cmd(OP_INSERT, -ONE + 64 * k, 100 * k, -k, 16'h0100 + k);
        queue_cmd(OP_QUERY, 1000, 1000, 1000, 0);
        queue_random(10, -ONE, 6 * ONE);
        settle();

        // Half-size cells, full grid, largest cutoff; contents kept.
        send_idle_pct = 75;
        write_grid(-2 * ONE, -2 * ONE, -2 * ONE, 2 * ONE, 16, 16, 16, CUTOFF_MAX);
        queue_random(10, -2 * ONE, 9 * ONE);
        settle();

        // Zero inverse cell size, zero cell counts, zero cutoff, top origin.
        send_idle_pct = 0;
        recv_stall_pct = 75;
        write_grid(8388607, 8388607, 8388607, 0, 0, 0, 0, 0);
        queue_random(10, -ONE, 4 * ONE);
        settle();

        // Lowest origin, largest inverse size, cell counts past the grid.
        send_idle_pct = 12;
        recv_stall_pct = 12;
        write_grid(-8388608, -8388608, -8388608, 24'hFF_FFFF, 31, 31, 31, 64'd1 << 26);
        queue_random(10, -ONE, 8 * ONE);
        settle();

        // Dense 3x2x1 grid so that queries overflow the emit limit.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_grid(0, 0, 0, ONE, 3, 2, 1, CUTOFF_MAX);
        queue_cmd(OP_CLEAR, 0, 0, 0, 0);
        for (int k = 0; k < 80; k++)
            queue_cmd(OP_INSERT, $urandom_range(0, 3 * ONE - 1), $urandom_range(0, 2 * ONE - 1),
                      $urandom_range(0, ONE - 1), IDENT_BITS'($urandom));
        for (int k = 0; k < 4; k++)
            queue_cmd(OP_QUERY, ONE + $urandom_range(0, ONE - 1),
                      $urandom_range(0, 2 * ONE - 1), $urandom_range(0, ONE - 1), 0);
        wait (cmd_backlog.size() == 0 && !cmd_busy && expected_results.size() == 0);
        repeat (600) @(posedge clk);

        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
